// ----- rtl/rrf_pkg.sv -----
// Shared types, sizes and command codes of the record ring FIFO.
`timescale 1ns / 1ps

package rrf_pkg;

   localparam int FIFO_DEPTH   = 16;
   localparam int RECORD_BYTES = 26;
   localparam int QUEUE_DEPTH  = 2;

   localparam int SLOT_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int CURSOR_W = $clog2(RECORD_BYTES);
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // Byte 0 sits in the least significant byte lane.
   typedef logic [RECORD_BYTES-1:0][7:0] record_type;

   typedef struct packed {
      logic       is_get;
      record_type record;
   } item_type;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] nxt;
      if (slot == SLOT_W'(FIFO_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// ----- rtl/rrf_front.sv -----
// Front end: accepts items, tags put or get, and buffers them in a short queue.
`timescale 1ns / 1ps

module rrf_front
   import rrf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_cmd,
   input  record_type req_record,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic               push;
   item_type           tagged_item;

   assign req_stall = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      tagged_item.is_get = (req_cmd == CMD_GET);
      tagged_item.record = req_record;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= tagged_item;
      end
   end

endmodule

// ----- rtl/rrf_back.sv -----
// Back end: ring indices, record memory, byte cursor and the result register.
`timescale 1ns / 1ps

module rrf_back
   import rrf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic [7:0] rsp_read_byte,
   output logic     rsp_byte_valid,
   output logic     rsp_record_done,
   output logic     rsp_fifo_empty,
   output logic     rsp_overwrite_seen
);

   record_type mem [FIFO_DEPTH];

   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                ovf_ff, ovf_in;

   logic                rsp_valid_ff;
   record_type          row_ff;
   logic [CURSOR_W-1:0] sel_ff;
   logic                byte_valid_ff, byte_valid_in;
   logic                done_ff, done_in;
   logic                empty_ff;
   logic                ovf_seen_ff;

   logic load;
   logic fire;
   logic do_put;
   logic do_get;

   assign load   = !rsp_valid_ff || !rsp_stall;
   assign fire   = q_valid && load;
   assign q_pop  = fire;
   assign do_put = fire && !q_item.is_get;
   assign do_get = fire && q_item.is_get && (count_ff != '0);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      ovf_in        = ovf_ff;
      byte_valid_in = 1'b0;
      done_in       = 1'b0;
      if (do_put) begin
         head_in = slot_next(head_ff);
         if (count_ff == CNT_W'(FIFO_DEPTH)) begin
            // Full: drop the oldest record, count holds.
            tail_in = slot_next(tail_ff);
            ovf_in  = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (do_get) begin
         byte_valid_in = 1'b1;
         if (cursor_ff == CURSOR_W'(RECORD_BYTES - 1)) begin
            cursor_in = '0;
            done_in   = 1'b1;
            tail_in   = slot_next(tail_ff);
            count_in  = count_ff - 1'b1;
         end else begin
            cursor_in = cursor_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         ovf_ff    <= ovf_in;
         if (load) begin
            rsp_valid_ff <= q_valid;
         end
      end
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_put) begin
         mem[head_ff] <= q_item.record;
      end
      if (do_get) begin
         row_ff <= mem[tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         sel_ff        <= cursor_ff;
         byte_valid_ff <= byte_valid_in;
         done_ff       <= done_in;
         empty_ff      <= (count_in == '0);
         ovf_seen_ff   <= ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_byte      = byte_valid_ff ? row_ff[sel_ff] : 8'h00;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_record_done    = done_ff;
   assign rsp_fifo_empty     = empty_ff;
   assign rsp_overwrite_seen = ovf_seen_ff;

endmodule

// ----- rtl/record_ring_fifo_byte_readout.sv -----
// Top level of the overwriting record ring FIFO with byte-serial readout.
// Path: an accepted item waits in the front queue, then loads the result register.
// Throughput: one put or one byte get per cycle while rsp_stall allows; the back end's
//   single execute stage (index update plus one record memory access) sets it.
// Reset: synchronous, active high; clears indices, count, cursor and overwrite flag.
//   Record memory needs no clearing: a get only reads slots a put has written.
`timescale 1ns / 1ps

module record_ring_fifo_byte_readout
   import rrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [63:0] req_rec_word0,
   input  logic [63:0] req_rec_word1,
   input  logic [63:0] req_rec_word2,
   input  logic [15:0] req_rec_tail_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_record_done,
   output logic        rsp_fifo_empty,
   output logic        rsp_overwrite_seen
);

   // Pack the record with byte 0 in the lowest lane.
   record_type req_record;
   assign req_record = {req_rec_tail_bytes, req_rec_word2, req_rec_word1, req_rec_word0};

   // Queue between front and back lets each side stall on its own.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   rrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_record (req_record),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end executes one item per cycle whenever the result register can load:
   // advance head/tail, write or read the record memory, step the byte cursor.
   rrf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_record_done    (rsp_record_done),
      .rsp_fifo_empty     (rsp_fifo_empty),
      .rsp_overwrite_seen (rsp_overwrite_seen)
   );

endmodule

// ----- test/tb_record_ring_fifo_byte_readout.sv -----
// Self-checking testbench for the record ring FIFO with byte-serial readout.
`timescale 1ns / 1ps

module tb_record_ring_fifo_byte_readout
   import rrf_pkg::*;
();

   // Quiet cycles allowed before the run is declared hung; well above the long hold-off.
   localparam int WATCHDOG_LIMIT = 1000;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES    = 150;
   // Cycles to watch the outputs after the last expected item, as a margin.
   localparam int SETTLE_CYCLES  = 8;
   // Random part: item count.
   localparam int RANDOM_ITEMS   = 450;
   // Chance, in percent, that either side idles in a given cycle.
   localparam int IDLE_PCT       = 34;
   // Random item windows for the hold-off, the sender pause and the no-idle stretch.
   localparam int HOLD_AT        = 40;
   localparam int PAUSE_AT       = 200;
   localparam int CALM_FROM      = 260;
   localparam int CALM_TO        = 360;

   // One result item as the block reports it.
   typedef struct packed {
      logic [7:0] read_byte;
      logic       byte_valid;
      logic       record_done;
      logic       fifo_empty;
      logic       overwrite_seen;
   } readout_type;

   // One row of the directed table; typed rows carry their expected item.
   typedef struct packed {
      logic        cmd;
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [15:0] tail_bytes;
      logic [8:0]  repeats;
      logic        typed;
      readout_type want;
   } plan_row_type;

   localparam int PLAN_ROWS = 9;

   // Directed part: empty get after reset, an all-ones record read partly, then fill
   // to the brim and overwrite the partly read record, so reading goes on at the same
   // byte position of the next record.
   plan_row_type plan [PLAN_ROWS] = '{
      '{CMD_GET, 64'h0, 64'h0, 64'h0, 16'h0, 9'd1, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{CMD_PUT, '1, '1, '1, '1, 9'd1, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_GET, 64'h0, 64'h0, 64'h0, 16'h0, 9'd3, 1'b1,
        '{8'hff, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{CMD_PUT, 64'h0, 64'h0, 64'h0, 16'h0, 9'd1, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_PUT, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
        16'h1918, 9'd1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_PUT, {4{16'h5555}}, {4{16'h5555}}, {4{16'h5555}}, 16'h5555, 9'd7, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_PUT, {4{16'haaaa}}, {4{16'haaaa}}, {4{16'haaaa}}, 16'haaaa, 9'd6, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_PUT, 64'hf8f9fafbfcfdfeff, 64'hf0f1f2f3f4f5f6f7, 64'he8e9eaebecedeeef,
        16'he6e7, 9'd1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CMD_GET, 64'h0, 64'h0, 64'h0, 16'h0, 9'd3, 1'b0,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}}
   };

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic        req_cmd            = CMD_PUT;
   logic [63:0] req_rec_word0      = '0;
   logic [63:0] req_rec_word1      = '0;
   logic [63:0] req_rec_word2      = '0;
   logic [15:0] req_rec_tail_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic        rsp_byte_valid;
   logic        rsp_record_done;
   logic        rsp_fifo_empty;
   logic        rsp_overwrite_seen;

   // Shadow copy of the FIFO, advanced once per accepted input item.
   record_type        shadow_store [FIFO_DEPTH];
   logic [SLOT_W-1:0] shadow_head      = '0;
   logic [SLOT_W-1:0] shadow_tail      = '0;
   int                shadow_count     = 0;
   int                shadow_cursor    = 0;
   logic              shadow_overwrite = 1'b0;

   readout_type pending_readouts [$];
   readout_type oldest;
   int          error_count   = 0;
   int          quiet_cycles  = 0;
   bit          calm          = 1'b0;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;

   record_ring_fifo_byte_readout dut (.*);

   always #1 clock = ~clock;

   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] slot);
      return (int'(slot) == FIFO_DEPTH - 1) ? '0 : slot + 1'b1;
   endfunction

   // Apply one item to the shadow FIFO and return the item the block should report.
   function automatic readout_type fifo_readout(input logic cmd, input record_type rec);
      readout_type r;
      r = '0;
      if (cmd == CMD_PUT) begin
         // Full: drop the oldest record, keep the count, latch the overwrite flag.
         if (shadow_count == FIFO_DEPTH) begin
            shadow_overwrite = 1'b1;
            shadow_tail      = wrap_slot(shadow_tail);
         end else begin
            shadow_count++;
         end
         shadow_store[shadow_head] = rec;
         shadow_head               = wrap_slot(shadow_head);
      end else if (shadow_count > 0) begin
         r.read_byte  = shadow_store[shadow_tail][shadow_cursor];
         r.byte_valid = 1'b1;
         // Last byte: wrap the cursor and retire the tail record.
         if (shadow_cursor == RECORD_BYTES - 1) begin
            shadow_cursor = 0;
            r.record_done = 1'b1;
            shadow_tail   = wrap_slot(shadow_tail);
            shadow_count--;
         end else begin
            shadow_cursor++;
         end
      end
      r.fifo_empty     = (shadow_count == 0);
      r.overwrite_seen = shadow_overwrite;
      return r;
   endfunction

   // Offer one item from a falling edge, hold it until accepted, and queue its
   // expected result. Returns at the falling edge after acceptance.
   task automatic offer_item(input logic cmd, input logic [63:0] w0, w1, w2,
                             input logic [15:0] tb, input logic typed,
                             input readout_type want);
      readout_type predicted;
      // Idle at random before the item, independent of stall.
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_rec_word0      <= w0;
      req_rec_word1      <= w1;
      req_rec_word2      <= w2;
      req_rec_tail_bytes <= tb;
      do @(posedge clock); while (req_stall);
      predicted = fifo_readout(cmd, {tb, w2, w1, w0});
      pending_readouts.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Receiver: random stall, a long hold-off on request, none during the calm stretch.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each accepted result item with the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readouts.size() == 0) begin
            $error("result item with no expectation waiting");
            error_count++;
         end else begin
            oldest = pending_readouts.pop_front();
            if (rsp_read_byte !== oldest.read_byte) begin
               $error("read_byte: expected %0h, got %0h", oldest.read_byte, rsp_read_byte);
               error_count++;
            end
            if (rsp_byte_valid !== oldest.byte_valid) begin
               $error("byte_valid: expected %0b, got %0b", oldest.byte_valid,
                      rsp_byte_valid);
               error_count++;
            end
            if (rsp_record_done !== oldest.record_done) begin
               $error("record_done: expected %0b, got %0b", oldest.record_done,
                      rsp_record_done);
               error_count++;
            end
            if (rsp_fifo_empty !== oldest.fifo_empty) begin
               $error("fifo_empty: expected %0b, got %0b", oldest.fifo_empty,
                      rsp_fifo_empty);
               error_count++;
            end
            if (rsp_overwrite_seen !== oldest.overwrite_seen) begin
               $error("overwrite_seen: expected %0b, got %0b", oldest.overwrite_seen,
                      rsp_overwrite_seen);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run once no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          issued;
      int          phase_left;
      int          put_pct;
      logic        cmd;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [63:0] w2;
      logic [15:0] tb;

      // Hold reset, then release it on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (plan[i]) begin
         repeat (plan[i].repeats) begin
            offer_item(plan[i].cmd, plan[i].word0, plan[i].word1, plan[i].word2,
                       plan[i].tail_bytes, plan[i].typed, plan[i].want);
         end
      end

      // Random part in phases, each with its own put rate. Gets dominate, since a
      // record takes 26 of them.
      issued     = 0;
      phase_left = 0;
      while (issued < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(60, 20);
            case ($urandom_range(5))
               0, 1, 2: put_pct = 0;
               3:       put_pct = 2;
               4:       put_pct = 4;
               default: put_pct = 50;
            endcase
         end
         phase_left--;

         // Back the block up: long receiver hold-off while items keep coming.
         if (issued == HOLD_AT) begin
            hold_requests <= hold_requests + 1;
         end
         // Pause the sender until every expected item has come back.
         if (issued == PAUSE_AT) begin
            req_valid <= 1'b0;
            wait (pending_readouts.size() == 0);
            @(negedge clock);
         end
         calm <= (issued >= CALM_FROM && issued < CALM_TO);

         cmd = ($urandom_range(99) < put_pct) ? CMD_PUT : CMD_GET;
         case ($urandom_range(9))
            0: begin
               w0 = '0;
               w1 = '0;
               w2 = '0;
               tb = '0;
            end
            1: begin
               w0 = '1;
               w1 = '1;
               w2 = '1;
               tb = '1;
            end
            default: begin
               w0 = {$urandom, $urandom};
               w1 = {$urandom, $urandom};
               w2 = {$urandom, $urandom};
               tb = 16'($urandom);
            end
         endcase
         offer_item(cmd, w0, w1, w2, tb, 1'b0, '0);
         issued++;
      end

      // Drop valid, wait out every expected item, then watch the outputs for the settle period.
      req_valid <= 1'b0;
      wait (pending_readouts.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && pending_readouts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
